[design/sha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam int MAX_CHUNKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NOT_OWNER  = 3'd3,
        ST_UNKNOWN    = 3'd4
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    // one row of the chunk table
    typedef struct packed {
        logic [31:0] hdr_addr;
        logic        busy;
        logic [7:0]  owner;
        logic        has_handler;
    } t_chunk;

endpackage
`default_nettype wire

[design/stack_heap_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stack heap allocator: chunks (header of HEADER_BYTES plus payload) are stacked up from
// heap_base; allocate bumps the heap top and returns the payload address, free marks the
// owner's chunk free and pops free chunks off the top. Writing heap_base or heap_size
// restarts the heap. One item is in flight at a time and s_axis_tready is low while it is
// worked on. A free reads the table rows from the top down to the match, and then pops
// free chunks until the stack is empty or a busy chunk is on top; a free of an unknown
// address reads every live row. The chunk table has a registered read, so each row
// searched takes a read state and a compare state. A finished result waits in the output
// register while the next beat is accepted; a result that finds that register still full
// holds the sequencer until the register drains.
module stack_heap_allocator_top #(
    parameter int MAX_CHUNKS   = sha_pkg::MAX_CHUNKS_DEF,
    parameter int HEADER_BYTES = sha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // alloc_size[31:0], block_address[63:32], caller_id[71:64],
    // has_release_handler[72], zero[79:73]
    input  wire logic [79:0] s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[2:0], payload_address[34:3], call_release[35], free_bytes[67:36],
    // zero[71:68]
    output logic      [71:0] m_axis_tdata
);
    import sha_pkg::*;

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam logic [31:0] HDR      = 32'(HEADER_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHUNKS);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_LEFT, S_ALLOC, S_SRCH_RD, S_SRCH_CMP, S_POP_RD, S_POP_CHK, S_RESULT
    } t_state;

    t_state      r_state;
    logic [31:0] r_base, r_size, r_end;
    logic [31:0] r_top;
    logic [CW-1:0] r_count, r_idx;
    logic [31:0] r_addr_req;
    logic [7:0]  r_caller;
    logic        r_handler;
    logic [32:0] r_need;
    logic [31:0] r_left;
    t_status     r_status;
    logic [31:0] r_payload;
    logic        r_release;
    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic        cfg_wr;
    logic [32:0] cfg_sum;
    logic [31:0] new_base, new_size;
    logic [31:0] left_now;
    logic        wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    t_chunk      wr_data, rd_data;
    logic        in_fire;

    sha_chunk_mem #(.DEPTH(MAX_CHUNKS)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? r_size : r_base;
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign new_base      = (cfg_wr && !paddr[2]) ? pwdata : r_base;
    assign new_size      = (cfg_wr &&  paddr[2]) ? pwdata : r_size;
    assign cfg_sum       = {1'b0, new_base} + {1'b0, new_size};
    assign left_now      = (r_top <= r_end) ? (r_end - r_top) : 32'd0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // table access
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IW-1:0];
        wr_data = '{hdr_addr: r_top, busy: 1'b1, owner: r_caller, has_handler: r_handler};
        rd_addr = r_idx[IW-1:0] - IW'(1);
        case (r_state)
            S_ALLOC: begin
                wr_en = (r_need <= {1'b0, r_left}) && (r_count != CNT_MAX);
            end
            S_SRCH_CMP: begin
                wr_addr = r_idx[IW-1:0];
                wr_data = rd_data;
                wr_data.busy = 1'b0;
                wr_en = ((rd_data.hdr_addr + HDR) == r_addr_req) &&
                        (rd_data.owner == r_caller);
            end
            S_POP_RD: begin
                rd_addr = r_count[IW-1:0] - IW'(1);
            end
            default: begin
                rd_addr = r_idx[IW-1:0] - IW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_size      <= '0;
            r_end       <= '0;
            r_top       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_base  <= new_base;
                r_size  <= new_size;
                r_end   <= cfg_sum[32] ? 32'hFFFF_FFFF : cfg_sum[31:0];
                r_top   <= new_base;
                r_count <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_addr_req <= s_axis_tdata[63:32];
                        r_caller   <= s_axis_tdata[71:64];
                        r_handler  <= s_axis_tdata[72];
                        r_need     <= {1'b0, s_axis_tdata[31:0]} + {1'b0, HDR};
                        r_status   <= ST_OK;
                        r_payload  <= '0;
                        r_release  <= 1'b0;
                        r_idx      <= r_count;
                        r_state    <= (s_axis_tuser[0] == CMD_FREE) ? S_SRCH_RD : S_LEFT;
                    end
                end
                S_LEFT: begin
                    r_left  <= left_now;
                    r_state <= S_ALLOC;
                end
                S_ALLOC: begin
                    if (r_need > {1'b0, r_left}) begin
                        r_status <= ST_NO_SPACE;
                    end else if (r_count == CNT_MAX) begin
                        r_status <= ST_TABLE_FULL;
                    end else begin
                        r_count   <= r_count + CNT_ONE;
                        r_payload <= r_top + HDR;
                        r_top     <= r_top + r_need[31:0];
                    end
                    r_state <= S_RESULT;
                end
                S_SRCH_RD: begin
                    if (r_idx == '0) begin
                        r_status <= ST_UNKNOWN;
                        r_state  <= S_RESULT;
                    end else begin
                        r_idx   <= r_idx - CNT_ONE;
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if ((rd_data.hdr_addr + HDR) != r_addr_req) begin
                        r_state <= S_SRCH_RD;
                    end else if (rd_data.owner != r_caller) begin
                        r_status <= ST_NOT_OWNER;
                        r_state  <= S_RESULT;
                    end else begin
                        r_release <= rd_data.busy & rd_data.has_handler;
                        r_state   <= S_POP_RD;
                    end
                end
                S_POP_RD: begin
                    r_state <= (r_count == '0) ? S_RESULT : S_POP_CHK;
                end
                S_POP_CHK: begin
                    if (!rd_data.busy) begin
                        // drop the free chunk on top
                        r_top   <= rd_data.hdr_addr;
                        r_count <= r_count - CNT_ONE;
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    // hold while the previous beat still waits in the output register
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'd0, left_now, r_release, r_payload, r_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/sha_chunk_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module sha_chunk_mem #(
    parameter int DEPTH = sha_pkg::MAX_CHUNKS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire sha_pkg::t_chunk          i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output sha_pkg::t_chunk               o_rd_data
);
    import sha_pkg::*;

    t_chunk r_mem [DEPTH];
    t_chunk r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[verif/tb_stack_heap_allocator_top.sv]
`timescale 1ns / 1ps
module tb_stack_heap_allocator_top;
    import sha_pkg::*;

    localparam logic [31:0] HDR         = 32'(HEADER_BYTES_DEF);
    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          DRAIN_WAIT  = 300;
    localparam logic [2:0]  REG_HEAP_BASE = 3'd0;
    localparam logic [2:0]  REG_HEAP_SIZE = 3'd4;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] size;
        logic [31:0] addr;
        logic [7:0]  caller;
        logic        handler;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] payload;
        logic        call_rel;
        logic [31:0] free_bytes;
    } t_outcome;

    // how the driver completes a request from the live heap state when it loads it
    typedef enum {AIM_NONE, AIM_LIVE, AIM_STRANGER, AIM_FIT, AIM_OVER} t_aim;

    typedef struct {
        t_req req;
        t_aim aim;
    } t_plan;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    stack_heap_allocator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // heap state as the block should hold it
    logic [31:0] cfg_base = '0;
    logic [31:0] cfg_size = '0;
    logic [31:0] pred_top = '0;
    int          live_cnt = 0;
    logic [31:0] tbl_hdr     [MAX_CHUNKS_DEF];
    logic        tbl_busy    [MAX_CHUNKS_DEF];
    logic [7:0]  tbl_owner   [MAX_CHUNKS_DEF];
    logic        tbl_handler [MAX_CHUNKS_DEF];

    t_plan    pending_q[$];
    t_outcome outcome_q[$];
    t_req     on_bus = '0;
    int       src_idle_pct = 30;
    int       snk_idle_pct = 58;
    int       n_fail = 0;
    int       n_results = 0;
    int       hold_left = 0;
    int       holds_done = 0;
    int       cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] bytes_left();
        logic [32:0] span;
        logic [31:0] lim;
        span = {1'b0, cfg_base} + {1'b0, cfg_size};
        lim  = span[32] ? 32'hFFFF_FFFF : span[31:0];
        return (pred_top <= lim) ? lim - pred_top : 32'd0;
    endfunction

    function automatic void heap_setup(logic [2:0] addr, logic [31:0] data);
        if (addr == REG_HEAP_BASE) begin
            cfg_base = data;
        end else if (addr == REG_HEAP_SIZE) begin
            cfg_size = data;
        end else begin
            return;
        end
        pred_top = cfg_base;
        live_cnt = 0;
    endfunction

    function automatic t_outcome heap_outcome(t_req r);
        t_outcome    o;
        logic [32:0] need;
        int          k;
        o = '0;
        o.status = ST_OK;
        if (r.cmd == CMD_ALLOC) begin
            need = {1'b0, r.size} + {1'b0, HDR};
            if (need > {1'b0, bytes_left()}) begin
                o.status = ST_NO_SPACE;
            end else if (live_cnt >= MAX_CHUNKS_DEF) begin
                o.status = ST_TABLE_FULL;
            end else begin
                tbl_hdr[live_cnt]     = pred_top;
                tbl_busy[live_cnt]    = 1'b1;
                tbl_owner[live_cnt]   = r.caller;
                tbl_handler[live_cnt] = r.handler;
                live_cnt++;
                o.payload = pred_top + HDR;
                pred_top  = pred_top + need[31:0];
            end
        end else begin
            // newest chunk wins
            k = live_cnt - 1;
            while (k >= 0 && tbl_hdr[k] + HDR != r.addr) k--;
            if (k < 0) begin
                o.status = ST_UNKNOWN;
            end else if (tbl_owner[k] != r.caller) begin
                o.status = ST_NOT_OWNER;
            end else begin
                o.call_rel = tbl_busy[k] & tbl_handler[k];
                tbl_busy[k] = 1'b0;
                while (live_cnt > 0 && !tbl_busy[live_cnt-1]) begin
                    pred_top = tbl_hdr[live_cnt-1];
                    live_cnt--;
                end
            end
        end
        o.free_bytes = bytes_left();
        return o;
    endfunction

    // every earlier beat is already predicted when this runs
    function automatic t_req aim_req(t_plan p);
        t_req        r;
        int          k;
        logic [31:0] left;
        r = p.req;
        case (p.aim)
            AIM_LIVE, AIM_STRANGER: begin
                if (live_cnt > 0) begin
                    k = $urandom_range(1) ? live_cnt - 1 : $urandom_range(live_cnt - 1);
                    r.addr   = tbl_hdr[k] + HDR;
                    r.caller = tbl_owner[k];
                    if (p.aim == AIM_STRANGER)
                        r.caller = tbl_owner[k] ^ 8'($urandom_range(1, 255));
                end
            end
            AIM_FIT, AIM_OVER: begin
                left = bytes_left();
                if (left >= HDR)
                    r.size = left - HDR + ((p.aim == AIM_OVER) ? 32'd1 : 32'd0);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_req(t_cmd cmd, logic [31:0] size, logic [31:0] addr,
                             logic [7:0] caller, logic handler);
        t_plan p;
        p.req.cmd     = cmd;
        p.req.size    = size;
        p.req.addr    = addr;
        p.req.caller  = caller;
        p.req.handler = handler;
        p.aim         = AIM_NONE;
        pending_q.push_back(p);
    endtask

    task automatic queue_mix(int n_items, int n_fill);
        t_plan p;
        int    pick;
        int    sub;
        for (int i = 0; i < n_items; i++) begin
            p.aim         = AIM_NONE;
            p.req.caller  = 8'($urandom_range(255));
            p.req.handler = 1'($urandom_range(1));
            p.req.size    = $urandom_range(64);
            p.req.addr    = $urandom();
            pick = (i < n_fill) ? 0 : $urandom_range(99);
            sub  = $urandom_range(19);
            if (pick < 50) begin
                p.req.cmd = CMD_ALLOC;
                if (sub < 2)
                    p.req.size = $urandom();
                else if (sub == 2 && i >= n_fill)
                    p.aim = AIM_FIT;
                else if (sub == 3 && i >= n_fill)
                    p.aim = AIM_OVER;
            end else begin
                p.req.cmd = CMD_FREE;
                if (pick < 88)
                    p.aim = AIM_LIVE;
                else if (pick < 93)
                    p.aim = AIM_STRANGER;
            end
            pending_q.push_back(p);
        end
    endtask

    // wait until nothing is queued, on the bus or outstanding
    task automatic settle(int extra);
        do @(posedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        heap_setup(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(logic [2:0] addr, logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("prdata: expected %h, got %h", want, prdata);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic heap_config(logic [31:0] base, logic [31:0] size, bit size_first);
        settle(10);
        if (size_first) begin
            cfg_write(REG_HEAP_SIZE, size);
            cfg_write(REG_HEAP_BASE, base);
        end else begin
            cfg_write(REG_HEAP_BASE, base);
            cfg_write(REG_HEAP_SIZE, size);
        end
        cfg_check(REG_HEAP_BASE, base);
        cfg_check(REG_HEAP_SIZE, size);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                outcome_q.push_back(heap_outcome(on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_bus = aim_req(pending_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, on_bus.handler, on_bus.caller,
                                      on_bus.addr, on_bus.size};
                    s_axis_tuser  <= on_bus.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_axis_tdata);
                    n_fail++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, m_axis_tdata[2:0]);
                        n_fail++;
                    end
                    if (m_axis_tdata[34:3] !== want.payload) begin
                        $error("payload_address: expected %h, got %h",
                               want.payload, m_axis_tdata[34:3]);
                        n_fail++;
                    end
                    if (m_axis_tdata[35] !== want.call_rel) begin
                        $error("call_release: expected %0d, got %0d",
                               want.call_rel, m_axis_tdata[35]);
                        n_fail++;
                    end
                    if (m_axis_tdata[67:36] !== want.free_bytes) begin
                        $error("free_bytes: expected %h, got %h",
                               want.free_bytes, m_axis_tdata[67:36]);
                        n_fail++;
                    end
                end
                n_results++;
            end
            // long hold-off so the block backs up into the request stream
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (holds_done < 2 && n_results >= 400 + 800 * holds_done &&
                         pending_q.size() > 16) begin
                hold_left = 600;
                holds_done++;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] base;
        logic [31:0] size;
        int          n_items;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_check(REG_HEAP_BASE, 32'd0);
        cfg_check(REG_HEAP_SIZE, 32'd0);

        // empty region after reset
        queue_req(CMD_ALLOC, 32'd0, 32'd0, 8'd0, 1'b0);
        queue_req(CMD_FREE, 32'd0, 32'h10, 8'd0, 1'b0);

        heap_config(32'h1000, 32'h100, 1'b0);
        queue_req(CMD_ALLOC, 32'd0, 32'd0, 8'd5, 1'b1);
        queue_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 8'hFF, 1'b1);
        queue_req(CMD_ALLOC, 32'h10, 32'd0, 8'd7, 1'b0);
        queue_req(CMD_FREE, 32'd0, 32'h1010, 8'd7, 1'b0);   // wrong owner
        queue_req(CMD_FREE, 32'd0, 32'h1010, 8'd5, 1'b0);   // handler fires, no pop
        queue_req(CMD_FREE, 32'd0, 32'h1010, 8'd5, 1'b0);   // repeated free
        queue_req(CMD_FREE, 32'd0, 32'h1234, 8'd5, 1'b0);   // unknown address
        queue_req(CMD_FREE, 32'd0, 32'h1020, 8'd7, 1'b0);   // pops down to empty stack
        queue_req(CMD_FREE, 32'd0, 32'h1020, 8'd7, 1'b0);
        queue_req(CMD_ALLOC, 32'hE0, 32'd0, 8'h80, 1'b1);
        queue_req(CMD_ALLOC, 32'd0, 32'd0, 8'h01, 1'b0);    // exact fit
        queue_req(CMD_ALLOC, 32'd0, 32'd0, 8'h01, 1'b0);

        // region end past the address space, rewritten with chunks still live
        settle(10);
        cfg_write(REG_HEAP_BASE, 32'hFFFF_FF00);
        cfg_check(REG_HEAP_BASE, 32'hFFFF_FF00);
        queue_req(CMD_ALLOC, 32'hEF, 32'd0, 8'h55, 1'b1);
        queue_req(CMD_ALLOC, 32'd0, 32'd0, 8'h55, 1'b1);
        queue_req(CMD_FREE, 32'd0, 32'hFFFF_FF10, 8'h55, 1'b0);

        heap_config(32'd0, 32'hFFFF_FFFF, 1'b1);
        queue_req(CMD_ALLOC, 32'hFFFF_FFEF, 32'd0, 8'hAA, 1'b0);
        queue_req(CMD_FREE, 32'd0, 32'h10, 8'hAA, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            settle(10);
            src_idle_pct <= (ph == 0) ? 30 : (ph == 1) ? 58 : 0;
            snk_idle_pct <= (ph == 0) ? 58 : (ph == 1) ? 30 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                n_items = 170;
                case (seg)
                    0: begin
                        heap_config($urandom_range(32'h7FFF_FFFF), 32'h0010_0000, 1'b0);
                        queue_mix(n_items, 70);
                    end
                    1: begin
                        heap_config($urandom(), 32'h600, 1'b1);
                        queue_mix(n_items, 0);
                    end
                    2: begin
                        if (ph == 0) begin
                            base = 32'd0;
                            size = 32'hFFFF_FFFF;
                        end else if (ph == 1) begin
                            base = 32'hFFFF_FF00;
                            size = 32'hFFFF_FFFF;
                            n_items = 90;
                        end else begin
                            base = 32'hFFFF_FFFF;
                            size = 32'd0;
                            n_items = 90;
                        end
                        heap_config(base, size, ph[0]);
                        queue_mix(n_items, (ph == 0) ? 70 : 0);
                    end
                    default: begin
                        heap_config($urandom_range(32'hFFFF_0000),
                                    $urandom_range(32'h100, 32'h4000), 1'b1);
                        queue_mix(n_items, 20);
                    end
                endcase
            end
        end

        settle(DRAIN_WAIT);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
